@@ design/lpf_pkg.sv @@
// lpf_pkg: shared widths, types, operation and condition codes, and the
// microprogram ROM for the least common multiple engine.
// No dependencies.
`timescale 1ns / 1ps

package lpf_pkg;

  // Operand width and derived sizes
  localparam int WIDTH = 32;
  localparam int KW    = $clog2(WIDTH);
  localparam int SW    = 4;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [KW-1:0]    count_t;
  typedef logic [SW-1:0]    step_t;
  typedef logic [3:0]       op_t;
  typedef logic [3:0]       cond_t;

  // Datapath operations
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_ACCEPT   = 4'd1;
  localparam op_t OP_ZERO     = 4'd2;
  localparam op_t OP_TWOS     = 4'd3;
  localparam op_t OP_U_ODD    = 4'd4;
  localparam op_t OP_GCD      = 4'd5;
  localparam op_t OP_DIV_INIT = 4'd6;
  localparam op_t OP_DIV_STEP = 4'd7;
  localparam op_t OP_MUL      = 4'd8;
  localparam op_t OP_PUT      = 4'd9;

  // Jump conditions
  localparam cond_t C_NEVER     = 4'd0;
  localparam cond_t C_ALWAYS    = 4'd1;
  localparam cond_t C_NO_INPUT  = 4'd2;
  localparam cond_t C_INVALID   = 4'd3;
  localparam cond_t C_BOTH_EVEN = 4'd4;
  localparam cond_t C_U_EVEN    = 4'd5;
  localparam cond_t C_V_NZ      = 4'd6;
  localparam cond_t C_DIV_MORE  = 4'd7;
  localparam cond_t C_OUT_BUSY  = 4'd8;

  // Program steps
  localparam step_t S_ACCEPT   = 4'd0;
  localparam step_t S_CHECK    = 4'd1;
  localparam step_t S_TWOS     = 4'd2;
  localparam step_t S_U_ODD    = 4'd3;
  localparam step_t S_GCD      = 4'd4;
  localparam step_t S_DIV_INIT = 4'd5;
  localparam step_t S_DIV_STEP = 4'd6;
  localparam step_t S_MUL      = 4'd7;
  localparam step_t S_PUT      = 4'd8;
  localparam step_t S_BACK     = 4'd9;

  // One control word per step
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Microprogram: jump to target when cond holds, else fall through
  function automatic ctrl_t rom_word(input step_t step);
    ctrl_t w;
    case (step)
      S_ACCEPT:   w = '{op: OP_ACCEPT,   cond: C_NO_INPUT,  target: S_ACCEPT};
      S_CHECK:    w = '{op: OP_ZERO,     cond: C_INVALID,   target: S_PUT};
      S_TWOS:     w = '{op: OP_TWOS,     cond: C_BOTH_EVEN, target: S_TWOS};
      S_U_ODD:    w = '{op: OP_U_ODD,    cond: C_U_EVEN,    target: S_U_ODD};
      S_GCD:      w = '{op: OP_GCD,      cond: C_V_NZ,      target: S_GCD};
      S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,     target: S_ACCEPT};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: S_DIV_STEP};
      S_MUL:      w = '{op: OP_MUL,      cond: C_NEVER,     target: S_ACCEPT};
      S_PUT:      w = '{op: OP_PUT,      cond: C_OUT_BUSY,  target: S_PUT};
      S_BACK:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: S_ACCEPT};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS,    target: S_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

@@ design/lpf_in_if.sv @@
// lpf_in_if: operand channel (valid, ready, two operands).
// Depends on lpf_pkg for the operand type.
`timescale 1ns / 1ps

interface lpf_in_if;
  logic          valid;
  logic          ready;
  lpf_pkg::word_t a_value;
  lpf_pkg::word_t b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

@@ design/lpf_out_if.sv @@
// lpf_out_if: result channel (valid, ready, least common multiple).
// Depends on lpf_pkg for the result type.
`timescale 1ns / 1ps

interface lpf_out_if;
  logic          valid;
  logic          ready;
  lpf_pkg::word_t multiple;

  modport source (output valid, output multiple, input ready);
  modport sink   (input valid, input multiple, output ready);
endinterface

@@ design/lcm_prime_factor.sv @@
// lcm_prime_factor: microcoded least common multiple engine.
// Depends on lpf_pkg, lpf_in_if and lpf_out_if.
//
// Usage:
//   in_ch carries one transaction per operand pair (a_value, b_value);
//   out_ch returns one transaction per pair with multiple = lcm(a, b)
//   modulo 2^WIDTH, or zero when either operand is zero or has its top
//   bit set.
//   The engine is a step counter walking a ten-word microprogram ROM over
//   a small datapath: binary GCD (strip common twos, make u odd, subtract
//   and halve), a restoring divide of (a >> k) by the odd GCD part, one
//   bit per cycle, and a combinational WIDTH x WIDTH multiply keeping the
//   low word.
//   The steps run accept, check, common twos, u odd, GCD, divide setup,
//   divide, multiply, put and back to accept; invalid operands go from the
//   check straight to put.
//   One pair is in flight at a time: in_ch.ready is high only at the
//   accept step. The result register frees the engine, so the next pair
//   is accepted while a finished result waits; if the receiver still
//   stalls when the next result is ready, the engine holds at its put step.
//   Reset (rst_n low, synchronous) returns to the accept step and empties
//   the result register.
`timescale 1ns / 1ps

module lcm_prime_factor (
  input  logic      clk,
  input  logic      rst_n,
  lpf_in_if.sink    in_ch,
  lpf_out_if.source out_ch
);

  // Sequencer and datapath registers
  lpf_pkg::step_t  step_r, step_nxt;
  lpf_pkg::word_t  a_r, a_nxt;
  lpf_pkg::word_t  b_r, b_nxt;
  lpf_pkg::word_t  u_r, u_nxt;
  lpf_pkg::word_t  v_r, v_nxt;
  lpf_pkg::count_t k_r, k_nxt;
  lpf_pkg::count_t cnt_r, cnt_nxt;
  lpf_pkg::word_t  quo_r, quo_nxt;
  lpf_pkg::word_t  rem_r, rem_nxt;
  lpf_pkg::word_t  res_r, res_nxt;
  lpf_pkg::word_t  out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;

  lpf_pkg::ctrl_t  ctrl;
  logic            cond_hit;
  logic            out_busy;
  logic            in_fire;
  logic            v_ge_u;
  lpf_pkg::word_t  v_minus_u;
  lpf_pkg::word_t  u_minus_v;
  logic [lpf_pkg::WIDTH:0]   div_trial;
  logic            div_ge;
  logic [2*lpf_pkg::WIDTH-1:0] product;

  // Fetch the control word
  assign ctrl = lpf_pkg::rom_word(step_r);

  assign in_ch.ready   = (step_r == lpf_pkg::S_ACCEPT);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_busy      = out_valid_r && !out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.multiple = out_data_r;

  // Shared arithmetic
  assign v_ge_u    = (v_r >= u_r);
  assign v_minus_u = v_r - u_r;
  assign u_minus_v = u_r - v_r;
  assign div_trial = {rem_r, quo_r[lpf_pkg::WIDTH-1]};
  assign div_ge    = (div_trial >= {1'b0, u_r});
  assign product   = quo_r * b_r;

  // Evaluate the jump condition on current values
  always_comb begin
    case (ctrl.cond)
      lpf_pkg::C_NEVER:     cond_hit = 1'b0;
      lpf_pkg::C_ALWAYS:    cond_hit = 1'b1;
      lpf_pkg::C_NO_INPUT:  cond_hit = !in_ch.valid;
      lpf_pkg::C_INVALID:   cond_hit = (a_r == '0) || (b_r == '0) ||
                                       a_r[lpf_pkg::WIDTH-1] || b_r[lpf_pkg::WIDTH-1];
      lpf_pkg::C_BOTH_EVEN: cond_hit = !u_r[0] && !v_r[0];
      lpf_pkg::C_U_EVEN:    cond_hit = !u_r[0];
      lpf_pkg::C_V_NZ:      cond_hit = (v_r != '0);
      lpf_pkg::C_DIV_MORE:  cond_hit = (cnt_r != lpf_pkg::count_t'(lpf_pkg::WIDTH - 1));
      lpf_pkg::C_OUT_BUSY:  cond_hit = out_busy;
      default:              cond_hit = 1'b0;
    endcase
  end

  // Advance the step counter
  always_comb begin
    if (cond_hit) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  // Datapath operations
  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (ctrl.op)
      lpf_pkg::OP_ACCEPT: begin
        if (in_fire) begin
          a_nxt = in_ch.a_value;
          b_nxt = in_ch.b_value;
          u_nxt = in_ch.a_value;
          v_nxt = in_ch.b_value;
          k_nxt = '0;
        end
      end
      lpf_pkg::OP_ZERO: begin
        res_nxt = '0;
      end
      lpf_pkg::OP_TWOS: begin
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end
      end
      lpf_pkg::OP_U_ODD: begin
        if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end
      end
      lpf_pkg::OP_GCD: begin
        // Binary GCD step: halve even v, else replace the larger by half the difference
        if (v_r != '0) begin
          if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (v_ge_u) begin
            v_nxt = v_minus_u >> 1;
          end else begin
            u_nxt = v_r;
            v_nxt = u_minus_v >> 1;
          end
        end
      end
      lpf_pkg::OP_DIV_INIT: begin
        quo_nxt = a_r >> k_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      lpf_pkg::OP_DIV_STEP: begin
        // Restoring division, one quotient bit per cycle
        if (div_ge) begin
          rem_nxt = lpf_pkg::word_t'(div_trial - {1'b0, u_r});
        end else begin
          rem_nxt = div_trial[lpf_pkg::WIDTH-1:0];
        end
        quo_nxt = {quo_r[lpf_pkg::WIDTH-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      lpf_pkg::OP_MUL: begin
        res_nxt = product[lpf_pkg::WIDTH-1:0];
      end
      lpf_pkg::OP_PUT: begin
        if (!out_busy) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= lpf_pkg::S_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // An accepted pair always moves on to the operand check
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (step_r == lpf_pkg::S_CHECK))
    else $error("accepted pair did not advance to check step");

  // A new result appears only from the put step
  assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r) |-> ($past(step_r) == lpf_pkg::S_PUT))
    else $error("result became valid outside the put step");

  // The GCD loop keeps u odd
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == lpf_pkg::S_GCD) |-> u_r[0])
    else $error("even u inside the GCD loop");

  // The GCD divides a exactly
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == lpf_pkg::S_MUL) |-> (rem_r == '0))
    else $error("nonzero remainder after dividing by the GCD");
`endif

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for the least common multiple engine.
// Depends on lpf_pkg, lpf_in_if, lpf_out_if and lcm_prime_factor.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 1830;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 2_000_000;

  // Expected multiples in acceptance order, checked as results come back
  class lcm_scoreboard;
    lpf_pkg::word_t pending_multiples[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned accepted;
    int unsigned invalid_pairs;

    // Euclid on widened operands, then (a / g) * b kept to the low word
    function lpf_pkg::word_t lcm_of(lpf_pkg::word_t a, lpf_pkg::word_t b);
      logic [2*lpf_pkg::WIDTH-1:0] x, y, r, prod;
      x = {{lpf_pkg::WIDTH{1'b0}}, a};
      y = {{lpf_pkg::WIDTH{1'b0}}, b};
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      prod = ({{lpf_pkg::WIDTH{1'b0}}, a} / x) * {{lpf_pkg::WIDTH{1'b0}}, b};
      return prod[lpf_pkg::WIDTH-1:0];
    endfunction

    function void note_operands(lpf_pkg::word_t a, lpf_pkg::word_t b);
      accepted++;
      // Zero or top bit set on either side forces a zero result
      if (a == '0 || b == '0 || a[lpf_pkg::WIDTH-1] || b[lpf_pkg::WIDTH-1]) begin
        invalid_pairs++;
        pending_multiples.push_back('0);
      end else begin
        pending_multiples.push_back(lcm_of(a, b));
      end
    endfunction

    function void check_multiple(lpf_pkg::word_t got);
      lpf_pkg::word_t want;
      if (pending_multiples.size() == 0) begin
        $error("multiple: expected none, actual %08h", got);
        mismatches++;
        return;
      end
      want = pending_multiples.pop_front();
      checked++;
      if (got !== want) begin
        $error("multiple: expected %08h, actual %08h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   send_quiet;
  int unsigned cycle_count;

  lpf_in_if  in_ch();
  lpf_out_if out_ch();

  lcm_scoreboard sb = new;

  lcm_prime_factor uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Log each operand transaction into the scoreboard
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_operands(in_ch.a_value, in_ch.b_value);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_multiple(out_ch.multiple);
  end

  // Offer one operand pair after a random gap (none in quiet stretches), hold until accepted
  task automatic send_pair(input lpf_pkg::word_t a, input lpf_pkg::word_t b);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.a_value <= a;
    in_ch.b_value <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering until every expected multiple has come back
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_multiples.size() != 0);
  endtask

  // Zero and top-bit operands, ones, wraps, common twos, coprimes
  task automatic run_directed();
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0007);
    send_pair(32'h0000_0007, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h0000_0003);
    send_pair(32'h0000_0003, 32'h8000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0001, 32'h8000_0001);
    send_pair(32'h0000_0001, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h0000_0001);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_pair(32'h7FFF_FFFE, 32'h7FFF_FFFD);
    send_pair(32'h0000_0002, 32'h7FFF_FFFF);
    send_pair(32'h4000_0000, 32'h0000_0003);
    send_pair(32'h4000_0000, 32'h2000_0000);
    send_pair(32'h0003_0000, 32'h0005_0000);
    send_pair(32'h5555_5555, 32'h2AAA_AAAA);
    send_pair(32'h0000_000C, 32'h0000_0012);
    send_pair(32'h0000_0007, 32'h0000_000D);
    send_pair(32'h0000_0006, 32'h0000_0006);
  endtask

  // Draw operands: shared-factor pairs, pairs with factors of two, shifted
  // random values, full-range noise and tiny values
  task automatic random_pair(output lpf_pkg::word_t a, output lpf_pkg::word_t b);
    int             kind;
    lpf_pkg::word_t g;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      a = $urandom;
      b = $urandom;
    end else if (kind < 20) begin
      a = $urandom_range(0, 20);
      b = $urandom_range(0, 20);
    end else if (kind < 45) begin
      g = $urandom >> $urandom_range(16, 31);
      if (g == '0) g = 1;
      a = (g * (($urandom >> $urandom_range(8, 31)) | 1)) & 32'h7FFF_FFFF;
      b = (g * (($urandom >> $urandom_range(8, 31)) | 1)) & 32'h7FFF_FFFF;
    end else if (kind < 60) begin
      a = ((($urandom >> $urandom_range(1, 31)) | 1) << $urandom_range(0, 30));
      b = ((($urandom >> $urandom_range(1, 31)) | 1) << $urandom_range(0, 30));
      a[lpf_pkg::WIDTH-1] = 1'b0;
      b[lpf_pkg::WIDTH-1] = 1'b0;
    end else begin
      a = $urandom >> $urandom_range(1, 31);
      b = $urandom >> $urandom_range(1, 31);
    end
  endtask

  // Result side: random stalls, quiet stretches, two long hold-offs
  initial begin : result_sink
    int stall;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == 60 || taken == 900)
        stall = LONG_HOLD;
      else
        stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Guard against a hung handshake
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    lpf_pkg::word_t a, b;
    int             n;
    send_quiet = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.a_value <= '0;
    in_ch.b_value <= '0;
    rst_n         <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    hold_until_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      random_pair(a, b);
      send_pair(a, b);
    end

    // Let the last results land, then watch for strays
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_multiples.size() != 0) begin
      $error("multiple: %0d expected results never arrived", sb.pending_multiples.size());
      sb.mismatches++;
    end

    $display("tb: %0d operand pairs accepted (%0d with zero or top-bit operands)",
             sb.accepted, sb.invalid_pairs);
    $display("tb: %0d multiples compared, %0d mismatches, %0d cycles",
             sb.checked, sb.mismatches, cycle_count);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
